// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the window-mean RTL.
// No dependencies; the assertion forms are left out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- hw/rtl/imu_wam_pkg.sv -----
// Types, fixed widths and codes for the IMU window axis mean block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package imu_wam_pkg;

  localparam int AXIS_COUNT = 6;
  localparam int SMP_W      = 16;
  localparam int TIME_W     = 48;
  localparam int MEAN_W     = 24;
  localparam int FRAC_W     = 8;

  typedef logic [1:0]               mode_t;
  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic [TIME_W-1:0]        time_t;
  typedef logic signed [MEAN_W-1:0] mean_t;

  // Item modes; any other code only reports
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_EVICT  = 2'd1;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // word taken: capture, insert when allowed
    logic ev_pop;    // drop the oldest sample
    logic div_load;  // start the six divisions
    logic div_step;  // one quotient bit on each lane
    logic out_load;  // fill the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ev_hit;    // oldest sample lies before the cutoff
  } dp_sts_t;

endpackage

// ----- hw/rtl/imu_wam_if.sv -----
// Valid/ready channel interfaces for the IMU window axis mean block.
// Depends on imu_wam_pkg.
interface imu_wam_in_if import imu_wam_pkg::*;;
  logic  valid;
  logic  ready;
  mode_t mode;
  time_t timestamp;
  smp_t  acc_x;
  smp_t  acc_y;
  smp_t  acc_z;
  smp_t  gyr_x;
  smp_t  gyr_y;
  smp_t  gyr_z;

  modport source (output valid, mode, timestamp, acc_x, acc_y, acc_z,
                  gyr_x, gyr_y, gyr_z, input ready);
  modport sink (input valid, mode, timestamp, acc_x, acc_y, acc_z,
                gyr_x, gyr_y, gyr_z, output ready);
endinterface

interface imu_wam_out_if import imu_wam_pkg::*; #(
  parameter int CNT_W = 9
);
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] sample_count;
  logic             dropped;
  mean_t            mean_acc_x;
  mean_t            mean_acc_y;
  mean_t            mean_acc_z;
  mean_t            mean_gyr_x;
  mean_t            mean_gyr_y;
  mean_t            mean_gyr_z;

  modport source (output valid, sample_count, dropped, mean_acc_x, mean_acc_y,
                  mean_acc_z, mean_gyr_x, mean_gyr_y, mean_gyr_z, input ready);
  modport sink (input valid, sample_count, dropped, mean_acc_x, mean_acc_y,
                mean_acc_z, mean_gyr_x, mean_gyr_y, mean_gyr_z, output ready);
endinterface

// ----- hw/rtl/imu_wam_ctrl.sv -----
// Sequencing state machine of the IMU window axis mean block.
// Depends on imu_wam_pkg and assert_macros.svh; drives imu_wam_dp.
`include "assert_macros.svh"

module imu_wam_ctrl import imu_wam_pkg::*; #(
  parameter int DIV_W = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    in_evict_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam int STEP_W = $clog2(DIV_W);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EV_RD  = 3'd1;
  localparam logic [2:0] S_EV_CHK = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] div_cnt_q, div_cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              div_last;

  assign div_last = (div_cnt_q == STEP_W'(DIV_W - 1));

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    div_cnt_d  = div_cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = in_evict_i ? S_EV_RD : S_LOAD;
        end
      end
      // read register settles on the current oldest entry
      S_EV_RD: begin
        state_d = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (sts_i.ev_hit) begin
          cmd_o.ev_pop = 1'b1;
          state_d      = S_EV_RD;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.div_load = 1'b1;
        div_cnt_d      = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result word held until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // One word in flight at a time
  `ASSERT_CLK(a_single_item, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // Division counter never runs past the last quotient bit
  `ASSERT_NEVER(a_div_cnt_range, clk_i, rst_ni, (state_q == S_DIV) && (div_cnt_q > STEP_W'(DIV_W - 1)))
  // A result is never loaded over an untaken one
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load && out_valid_q && !out_ready_i)

endmodule

// ----- hw/rtl/imu_wam_dp.sv -----
// Datapath of the IMU window axis mean block: sample rings, running sums,
// six restoring dividers and the result register. Depends on imu_wam_pkg.
`include "assert_macros.svh"

module imu_wam_dp import imu_wam_pkg::*; #(
  parameter int WINDOW_DEPTH = 256,
  parameter int CNT_W        = 9,
  parameter int PTR_W        = 8,
  parameter int SUM_W        = 24,
  parameter int DIV_W        = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  input  mode_t            in_mode_i,
  input  time_t            in_time_i,
  input  smp_t             in_smp_i [AXIS_COUNT],
  output logic [CNT_W-1:0] out_count_o,
  output logic             out_dropped_o,
  output mean_t            out_mean_o [AXIS_COUNT]
);

  localparam int ROW_W = AXIS_COUNT * SMP_W;

  // Window state
  logic [CNT_W-1:0]        count_q;
  logic [PTR_W-1:0]        oldest_q;
  logic signed [SUM_W-1:0] sum_q [AXIS_COUNT];
  time_t                   newest_q;
  time_t                   cut_q;
  logic                    dropped_q;

  // Sample rings and their read register
  time_t             time_mem [WINDOW_DEPTH];
  logic [ROW_W-1:0]  axis_mem [WINDOW_DEPTH];
  time_t             rd_time_q;
  logic [ROW_W-1:0]  rd_axis_q;

  // Divider lanes
  logic [CNT_W-1:0]  rem_q [AXIS_COUNT];
  logic [DIV_W-1:0]  quo_q [AXIS_COUNT];
  logic              neg_q [AXIS_COUNT];

  // Result register
  logic [CNT_W-1:0]  out_count_q;
  logic              out_dropped_q;
  mean_t             out_mean_q [AXIS_COUNT];

  logic              is_ins, full, stale, ins_ok, do_ins;
  logic [CNT_W:0]    wr_sum;
  logic [PTR_W-1:0]  wr_ptr, oldest_nx;
  logic [ROW_W-1:0]  smp_row;
  logic [SUM_W-1:0]  mag   [AXIS_COUNT];
  logic [CNT_W:0]    shl   [AXIS_COUNT];
  logic [CNT_W:0]    diff  [AXIS_COUNT];
  logic              ge    [AXIS_COUNT];
  logic [MEAN_W-1:0] q_lo  [AXIS_COUNT];

  // Insert check against fill level and newest time
  assign is_ins = (in_mode_i == MODE_INSERT);
  assign full   = (count_q == CNT_W'(WINDOW_DEPTH));
  assign stale  = (count_q != '0) && (in_time_i <= newest_q);
  assign ins_ok = is_ins && !full && !stale;
  assign do_ins = cmd_i.accept && ins_ok;

  // Ring positions wrap at the depth
  assign wr_sum    = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(count_q);
  assign wr_ptr    = (wr_sum >= (CNT_W+1)'(WINDOW_DEPTH)) ?
                     PTR_W'(wr_sum - (CNT_W+1)'(WINDOW_DEPTH)) : PTR_W'(wr_sum);
  assign oldest_nx = (oldest_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

  always_comb begin
    for (int a = 0; a < AXIS_COUNT; a++) begin
      smp_row[a*SMP_W +: SMP_W] = in_smp_i[a];
    end
  end

  // Rings: one write port, one registered read of the oldest entry
  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      time_mem[wr_ptr] <= in_time_i;
      axis_mem[wr_ptr] <= smp_row;
    end
    rd_time_q <= time_mem[oldest_q];
    rd_axis_q <= axis_mem[oldest_q];
  end

  assign sts_o.ev_hit = (count_q != '0) && (rd_time_q < cut_q);

  // Fill level, oldest pointer and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      oldest_q <= '0;
      for (int a = 0; a < AXIS_COUNT; a++) begin
        sum_q[a] <= '0;
      end
    end else if (do_ins) begin
      count_q <= count_q + 1'b1;
      for (int a = 0; a < AXIS_COUNT; a++) begin
        sum_q[a] <= sum_q[a] + SUM_W'(in_smp_i[a]);
      end
    end else if (cmd_i.ev_pop) begin
      count_q  <= count_q - 1'b1;
      oldest_q <= oldest_nx;
      for (int a = 0; a < AXIS_COUNT; a++) begin
        sum_q[a] <= sum_q[a] - SUM_W'($signed(rd_axis_q[a*SMP_W +: SMP_W]));
      end
    end
  end

  // Per-word captures
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cut_q     <= in_time_i;
      dropped_q <= is_ins && !ins_ok;
    end
    if (do_ins) begin
      newest_q <= in_time_i;
    end
  end

  // Restoring division of |sum| * 2^FRAC_W by the count, one bit a cycle
  always_comb begin
    for (int a = 0; a < AXIS_COUNT; a++) begin
      mag[a]  = sum_q[a][SUM_W-1] ? SUM_W'(-sum_q[a]) : SUM_W'(sum_q[a]);
      shl[a]  = {rem_q[a], quo_q[a][DIV_W-1]};
      ge[a]   = (shl[a] >= {1'b0, count_q});
      diff[a] = shl[a] - {1'b0, count_q};
      q_lo[a] = quo_q[a][MEAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < AXIS_COUNT; a++) begin
      if (cmd_i.div_load) begin
        rem_q[a] <= '0;
        quo_q[a] <= {mag[a], FRAC_W'(0)};
        neg_q[a] <= sum_q[a][SUM_W-1];
      end else if (cmd_i.div_step) begin
        rem_q[a] <= ge[a] ? diff[a][CNT_W-1:0] : shl[a][CNT_W-1:0];
        quo_q[a] <= {quo_q[a][DIV_W-2:0], ge[a]};
      end
    end
  end

  // Result register; empty window reads as zero means
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_count_q   <= count_q;
      out_dropped_q <= dropped_q;
      for (int a = 0; a < AXIS_COUNT; a++) begin
        if (count_q == '0) begin
          out_mean_q[a] <= '0;
        end else begin
          out_mean_q[a] <= neg_q[a] ? -q_lo[a] : q_lo[a];
        end
      end
    end
  end

  assign out_count_o   = out_count_q;
  assign out_dropped_o = out_dropped_q;
  assign out_mean_o    = out_mean_q;

  // Fill level and pointer stay inside the window
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(WINDOW_DEPTH))
  `ASSERT_NEVER(a_ptr_range, clk_i, rst_ni, oldest_q > PTR_W'(WINDOW_DEPTH - 1))
  // An eviction removes exactly one sample
  `ASSERT_CLK(a_pop_count, clk_i, rst_ni, cmd_i.ev_pop |=> (count_q == $past(count_q) - 1'b1))

endmodule

// ----- hw/rtl/imu_window_axis_mean_unit.sv -----
// Top level of the IMU window axis mean block: controller plus datapath.
// Depends on imu_wam_pkg, imu_wam_if, imu_wam_ctrl and imu_wam_dp.
//
// Holds a time-ordered window of up to WINDOW_DEPTH six-axis samples and
// returns one word per input word: the sample count and six per-axis means
// in Q15.8, truncated toward zero. Words are handled one at a time. An insert
// or report word passes through the load state and the six restoring dividers,
// which produce one quotient bit per cycle over DIV_W = 24 + clog2(depth) bits,
// and reaches the output register once that register is free. An evict word
// first removes samples one at a time, each through the read and check states,
// then makes a final read and check before dividing, since the sample ring has a
// single registered read port. The next word is accepted from the cycle after
// the result is loaded into the output register, even while that result still
// waits to be taken. The sample memories need no clearing after reset.

module imu_window_axis_mean_unit import imu_wam_pkg::*; #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  imu_wam_in_if.sink   in_i,
  imu_wam_out_if.source out_o
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = SMP_W + $clog2(WINDOW_DEPTH);
  localparam int DIV_W = SUM_W + FRAC_W;

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  smp_t             in_smp  [AXIS_COUNT];
  mean_t            out_mean [AXIS_COUNT];
  logic [CNT_W-1:0] out_count;
  logic             out_dropped;
  logic             in_evict;

  assign in_smp[0] = in_i.acc_x;
  assign in_smp[1] = in_i.acc_y;
  assign in_smp[2] = in_i.acc_z;
  assign in_smp[3] = in_i.gyr_x;
  assign in_smp[4] = in_i.gyr_y;
  assign in_smp[5] = in_i.gyr_z;

  assign in_evict = (in_i.mode == MODE_EVICT);

  imu_wam_ctrl #(
    .DIV_W (DIV_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_evict_i  (in_evict),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  imu_wam_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .CNT_W        (CNT_W),
    .PTR_W        (PTR_W),
    .SUM_W        (SUM_W),
    .DIV_W        (DIV_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_mode_i     (in_i.mode),
    .in_time_i     (in_i.timestamp),
    .in_smp_i      (in_smp),
    .out_count_o   (out_count),
    .out_dropped_o (out_dropped),
    .out_mean_o    (out_mean)
  );

  assign out_o.sample_count = out_count;
  assign out_o.dropped      = out_dropped;
  assign out_o.mean_acc_x   = out_mean[0];
  assign out_o.mean_acc_y   = out_mean[1];
  assign out_o.mean_acc_z   = out_mean[2];
  assign out_o.mean_gyr_x   = out_mean[3];
  assign out_o.mean_gyr_y   = out_mean[4];
  assign out_o.mean_gyr_z   = out_mean[5];

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for the IMU window axis mean block: drives words through the
// valid/ready channels and compares every result word with a window model of its own.
// Depends on imu_wam_pkg, imu_wam_if and imu_window_axis_mean_unit.
module tb_top import imu_wam_pkg::*;;

  localparam int    WIN_DEPTH   = 256;
  localparam int    CNT_W       = 9;
  localparam mode_t MODE_REPORT = 2'd2;
  localparam mode_t MODE_SPARE  = 2'd3;   // unused code, behaves as report
  localparam time_t STAMP_TOP   = 48'hFFFF_FF00_0000;
  localparam int    RAND_WORDS  = 450;
  localparam int    HOLD_AT     = 120;    // result count at which the sink stalls
  localparam int    HOLD_CYCLES = 400;
  localparam int    MAX_REPORTS = 10;

  typedef struct {
    mode_t mode;
    time_t stamp;
    smp_t  axis[AXIS_COUNT];
  } imu_word_t;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic             dropped;
    mean_t            mean[AXIS_COUNT];
  } mean_word_t;

  // Window model plus the queue of result words still owed by the block
  class window_mean_board;
    imu_word_t  held_q[$];
    longint     axis_sum[AXIS_COUNT];
    mean_word_t expected_means[$];
    int         errors;

    function new();
      errors = 0;
      foreach (axis_sum[a]) axis_sum[a] = 0;
    endfunction

    function int held();
      return held_q.size();
    endfunction

    function time_t oldest();
      return (held_q.size() > 0) ? held_q[0].stamp : '0;
    endfunction

    function time_t newest();
      return (held_q.size() > 0) ? held_q[$].stamp : '0;
    endfunction

    function int pending();
      return expected_means.size();
    endfunction

    // Update the window for one accepted word and queue the result it owes
    function void note_word(imu_word_t w);
      mean_word_t r;
      longint     q;
      r.dropped = 1'b0;
      case (w.mode)
        MODE_INSERT: begin
          if (held_q.size() >= WIN_DEPTH ||
              (held_q.size() > 0 && w.stamp <= held_q[$].stamp)) begin
            r.dropped = 1'b1;
          end else begin
            held_q.push_back(w);
            for (int a = 0; a < AXIS_COUNT; a++) axis_sum[a] += w.axis[a];
          end
        end
        MODE_EVICT: begin
          while (held_q.size() > 0 && held_q[0].stamp < w.stamp) begin
            for (int a = 0; a < AXIS_COUNT; a++) axis_sum[a] -= held_q[0].axis[a];
            void'(held_q.pop_front());
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(held_q.size());
      for (int a = 0; a < AXIS_COUNT; a++) begin
        q = 0;
        if (held_q.size() > 0) q = (axis_sum[a] * 256) / longint'(held_q.size());
        r.mean[a] = q[MEAN_W-1:0];
      end
      expected_means.push_back(r);
    endfunction

    // Compare one result word with the oldest one owed
    function void check_word(mean_word_t got);
      mean_word_t exp_w;
      bit         bad;
      if (expected_means.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result word with none owed: count %0d dropped %0d",
                   got.count, got.dropped);
        return;
      end
      exp_w = expected_means.pop_front();
      bad = (got.count !== exp_w.count) || (got.dropped !== exp_w.dropped);
      for (int a = 0; a < AXIS_COUNT; a++) if (got.mean[a] !== exp_w.mean[a]) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch: exp cnt %0d drop %0d means %0d %0d %0d %0d %0d %0d",
                   exp_w.count, exp_w.dropped, exp_w.mean[0], exp_w.mean[1],
                   exp_w.mean[2], exp_w.mean[3], exp_w.mean[4], exp_w.mean[5]);
          $display("          got cnt %0d drop %0d means %0d %0d %0d %0d %0d %0d",
                   got.count, got.dropped, got.mean[0], got.mean[1],
                   got.mean[2], got.mean[3], got.mean[4], got.mean[5]);
        end
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  imu_wam_in_if                  in_bus ();
  imu_wam_out_if #(.CNT_W(CNT_W)) out_bus ();

  imu_window_axis_mean_unit #(.WINDOW_DEPTH(WIN_DEPTH)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  window_mean_board board = new();
  int sent_words = 0;
  int got_words  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Runs of words with no idling on either side
  function automatic bit quiet_phase(int n);
    return ((n / 40) % 4) == 3;
  endfunction

  function automatic smp_t rand_axis();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3:       return '1;
      default: return smp_t'($urandom());
    endcase
  endfunction

  function automatic time_t rand_stamp();
    time_t t;
    t = time_t'({$urandom(), $urandom()});
    if (t > STAMP_TOP) t = t - 48'h100_0000;
    return t;
  endfunction

  function automatic imu_word_t make_word(mode_t m, time_t t);
    imu_word_t w;
    w.mode  = m;
    w.stamp = t;
    for (int a = 0; a < AXIS_COUNT; a++) w.axis[a] = rand_axis();
    return w;
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input imu_word_t w);
    int gap;
    gap = quiet_phase(sent_words) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.mode      <= w.mode;
    in_bus.timestamp <= w.stamp;
    in_bus.acc_x     <= w.axis[0];
    in_bus.acc_y     <= w.axis[1];
    in_bus.acc_z     <= w.axis[2];
    in_bus.gyr_x     <= w.axis[3];
    in_bus.gyr_y     <= w.axis[4];
    in_bus.gyr_z     <= w.axis[5];
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    board.note_word(w);
    sent_words++;
  endtask

  task automatic send_axes(input mode_t m, input time_t t, input smp_t v0, input smp_t v1,
                           input smp_t v2, input smp_t v3, input smp_t v4, input smp_t v5);
    imu_word_t w;
    w.mode    = m;
    w.stamp   = t;
    w.axis[0] = v0;
    w.axis[1] = v1;
    w.axis[2] = v2;
    w.axis[3] = v3;
    w.axis[4] = v4;
    w.axis[5] = v5;
    send_word(w);
  endtask

  // One random word; mostly well-formed inserts and evictions
  task automatic random_word(input bit filling);
    int     pick;
    time_t  t;
    longint span;
    pick = $urandom_range(0, 99);
    // stamps near the top of the range: empty the window and start afresh
    if (board.held() > 0 && board.newest() > STAMP_TOP) begin
      send_word(make_word(MODE_EVICT, '1));
      return;
    end
    if (filling) begin
      if (pick < 85) pick = 0;
      else if (pick < 90) pick = 1;
      else if (pick < 95) pick = 2;
      else pick = 3;
    end else begin
      if (pick < 45) pick = 0;
      else if (pick < 55) pick = 1;
      else if (pick < 70) pick = 2;
      else if (pick < 88) pick = 4;
      else if (pick < 95) pick = 5;
      else pick = 6;
    end
    if (pick == 1 && board.held() == 0) pick = 0;
    case (pick)
      0: begin
        t = (board.held() == 0) ? rand_stamp() : board.newest() + $urandom_range(1, 64);
        send_word(make_word(MODE_INSERT, t));
      end
      1: begin
        // stale: equal to or a little older than the newest
        t = board.newest();
        span = $urandom_range(0, 3);
        if (t >= span) t = t - time_t'(span);
        send_word(make_word(MODE_INSERT, t));
      end
      2: send_word(make_word(($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_REPORT,
                             rand_stamp()));
      3: send_word(make_word(MODE_EVICT, board.oldest()));   // removes nothing
      4: begin
        span = longint'(board.newest() - board.oldest()) + 1;
        t = board.oldest() + $urandom_range(0, int'(span));
        send_word(make_word(MODE_EVICT, t));
      end
      5: send_word(make_word(MODE_EVICT, board.newest() + 1));
      default: send_word(make_word(MODE_EVICT, time_t'({$urandom(), $urandom()})));
    endcase
  endtask

  // Sender: reset, directed words, then random words
  initial begin
    in_bus.valid     <= 1'b0;
    in_bus.mode      <= MODE_REPORT;
    in_bus.timestamp <= '0;
    in_bus.acc_x     <= '0;
    in_bus.acc_y     <= '0;
    in_bus.acc_z     <= '0;
    in_bus.gyr_x     <= '0;
    in_bus.gyr_y     <= '0;
    in_bus.gyr_z     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty window: report, evict, first insert with any stamp
    send_axes(MODE_REPORT, '0, 0, 0, 0, 0, 0, 0);
    send_axes(MODE_EVICT, '1, 1, 2, 3, 4, 5, 6);
    send_axes(MODE_INSERT, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    // stale equal stamp
    send_axes(MODE_INSERT, '0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_axes(MODE_INSERT, 48'd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h8000);
    // stale older stamp
    send_axes(MODE_INSERT, '0, 7, 7, 7, 7, 7, 7);
    // small values: means truncate toward zero over three samples
    send_axes(MODE_INSERT, 48'd5, 1, -1, 0, 2, -2, 3);
    send_axes(MODE_SPARE, 48'hDEAD_BEEF_0123, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1, 2);
    // cutoff equal to the oldest removes nothing, then one at a time
    send_axes(MODE_EVICT, '0, 0, 0, 0, 0, 0, 0);
    send_axes(MODE_EVICT, 48'd1, 0, 0, 0, 0, 0, 0);
    send_axes(MODE_EVICT, 48'd2, 0, 0, 0, 0, 0, 0);
    send_axes(MODE_INSERT, 48'h5555_5555_5555, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
              16'h5555, 16'hAAAA);
    send_axes(MODE_INSERT, 48'hAAAA_AAAA_AAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
              16'hAAAA, 16'h5555);
    send_axes(MODE_INSERT, 48'hFFFF_FFFF_FFFE, -1, -1, -1, 1, 1, 1);
    send_axes(MODE_INSERT, 48'hFFFF_FFFF_FFFE, 9, 9, 9, 9, 9, 9);
    send_axes(MODE_REPORT, '1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_axes(MODE_EVICT, 48'h8000_0000_0000, 0, 0, 0, 0, 0, 0);
    send_axes(MODE_EVICT, '1, 0, 0, 0, 0, 0, 0);
    // after emptying, an older stamp than before is accepted
    send_axes(MODE_INSERT, 48'h8000_0000_0000, 100, -100, 200, -200, 300, -300);
    send_axes(MODE_EVICT, '1, 0, 0, 0, 0, 0, 0);

    // fill the window to the brim, then knock on it while full
    while (board.held() < WIN_DEPTH) random_word(1'b1);
    repeat (6) send_word(make_word(MODE_INSERT, board.newest() + 1));
    // mixed traffic for the rest
    while (sent_words < RAND_WORDS + 20) random_word(1'b0);
    in_bus.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Sink: random stalls, one long hold-off, check every word taken
  initial begin
    int         wait_cycles;
    mean_word_t got;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      wait_cycles = quiet_phase(got_words + 20) ? 0 : $urandom_range(0, 8);
      if (got_words == HOLD_AT) wait_cycles = HOLD_CYCLES;
      if (wait_cycles > 0) begin
        out_bus.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
      got.count   = out_bus.sample_count;
      got.dropped = out_bus.dropped;
      got.mean[0] = out_bus.mean_acc_x;
      got.mean[1] = out_bus.mean_acc_y;
      got.mean[2] = out_bus.mean_acc_z;
      got.mean[3] = out_bus.mean_gyr_x;
      got.mean[4] = out_bus.mean_gyr_y;
      got.mean[5] = out_bus.mean_gyr_z;
      board.check_word(got);
      got_words++;
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/imu_wam_pkg.sv
hw/rtl/imu_wam_if.sv
hw/rtl/imu_wam_ctrl.sv
hw/rtl/imu_wam_dp.sv
hw/rtl/imu_window_axis_mean_unit.sv
test/tb_top.sv
